/* design/sit_pkg.sv */
// shell inertia tensor package: widths, payload types, register indexes
// and the coordinate sign-extension helper; no dependencies
`timescale 1ns / 1ps

package sit_pkg;

    // significant bits of the coordinate and mass fields
    localparam int COORD_WIDTH = 24;
    localparam int MASS_WIDTH  = 16;

    // fixed field widths
    localparam int POS_W    = 24;
    localparam int MASS_W   = 16;
    localparam int RADIUS_W = 23;
    localparam int ACC_W    = 64;
    localparam int COUNT_W  = 32;

    // derived arithmetic widths
    localparam int COORD_SHIFT = POS_W - COORD_WIDTH;
    localparam int SQ_W        = 2 * POS_W - 1;
    localparam int R2_W        = SQ_W + 1;
    localparam int PROD_W      = 2 * POS_W;
    localparam int RSQ_W       = 2 * RADIUS_W;
    localparam int TERM_SHIFT  = 16;
    localparam int TERM_W      = MASS_W + PROD_W + 1 - TERM_SHIFT;

    localparam logic [MASS_W-1:0] MASS_MASK = MASS_W'((1 << MASS_WIDTH) - 1);

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_INNER = 1'b0;
    localparam logic REG_OUTER = 1'b1;
    localparam logic [RADIUS_W-1:0] INNER_RESET = '0;
    localparam logic [RADIUS_W-1:0] OUTER_RESET = '1;

    // work queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [POS_W-1:0]  t_pos;
    typedef logic        [MASS_W-1:0] t_mass;
    typedef logic        [SQ_W-1:0]   t_sq;
    typedef logic        [R2_W-1:0]   t_r2;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic        [RSQ_W-1:0]  t_rsq;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [TERM_W-1:0] t_term;
    typedef logic        [COUNT_W-1:0] t_count;

    localparam t_acc   ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc   ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};
    localparam t_count COUNT_MAX = '1;

    // squared shell radii
    typedef struct packed {
        t_rsq inner_sq;
        t_rsq outer_sq;
    } t_shell;

    // one classified particle handed from front to back
    typedef struct packed {
        t_mass mass;
        t_r2   sum_yz;
        t_r2   sum_xz;
        t_r2   sum_xy;
        t_prod prod_xy;
        t_prod prod_xz;
        t_prod prod_yz;
        logic  hit;
        logic  last;
    } t_work;

    // keep the low COORD_WIDTH bits, sign extended
    function automatic t_pos sext_coord(t_pos raw);
        t_pos v;
        v = raw <<< COORD_SHIFT;
        return v >>> COORD_SHIFT;
    endfunction

endpackage

/* design/sit_in_if.sv */
// particle input channel: valid/ready with position, mass and last marker
// depends on sit_pkg
`timescale 1ns / 1ps

interface sit_in_if;
    import sit_pkg::*;

    logic  valid;
    logic  ready;
    t_pos  pos_x;
    t_pos  pos_y;
    t_pos  pos_z;
    t_mass particle_mass;
    logic  last_particle;

    modport source (
        output valid, pos_x, pos_y, pos_z, particle_mass, last_particle,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, particle_mass, last_particle,
        output ready
    );
endinterface

/* design/sit_out_if.sv */
// tensor result channel: valid/ready with six tensor elements, count, flag
// depends on sit_pkg
`timescale 1ns / 1ps

interface sit_out_if;
    import sit_pkg::*;

    logic   valid;
    logic   ready;
    t_acc   tensor_xx;
    t_acc   tensor_xy;
    t_acc   tensor_xz;
    t_acc   tensor_yy;
    t_acc   tensor_yz;
    t_acc   tensor_zz;
    t_count shell_count;
    logic   overflow_flag;

    modport source (
        output valid, tensor_xx, tensor_xy, tensor_xz, tensor_yy, tensor_yz,
               tensor_zz, shell_count, overflow_flag,
        input  ready
    );
    modport sink (
        input  valid, tensor_xx, tensor_xy, tensor_xz, tensor_yy, tensor_yz,
               tensor_zz, shell_count, overflow_flag,
        output ready
    );
endinterface

/* design/shell_inertia_tensor.sv */
// shell inertia tensor top level: register file, front end, work queue and
// back end; depends on sit_pkg, sit_in_if, sit_out_if and the sit_ modules
//
//   channel      dir  protocol     contents
//   i_particle   in   valid/ready  pos_x, pos_y, pos_z, particle_mass, last_particle
//   o_tensor     out  valid/ready  six tensor elements, shell_count, overflow_flag
//   apb          in   psel/penable inner_radius at 0x0, outer_radius at 0x4
//
// one particle a cycle is taken while the front is not held; the rate is set by the
// front multipliers, which start a new product set on every cycle that is not held
// a result passes stages 1 and 2, the queue, the term stage and the result register
// reset is synchronous and active low; it clears the sums, count and flag
// the front holds only when the 4-entry work queue is full, the back only
// while a finished result has not been taken
`timescale 1ns / 1ps

module shell_inertia_tensor (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    sit_in_if.sink                     i_particle,
    sit_out_if.source                  o_tensor,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sit_pkg::ADDR_W-1:0] paddr,
    input  logic [sit_pkg::DATA_W-1:0] pwdata,
    output logic [sit_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import sit_pkg::*;

    t_shell shell;
    t_work  push_work;
    t_work  pop_work;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;

    // configuration registers
    sit_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_shell (shell)
    );

    // particle intake and shell test
    sit_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_particle (i_particle),
        .i_shell    (shell),
        .i_full     (full),
        .o_push     (push),
        .o_work     (push_work)
    );

    // decoupling queue
    sit_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (push_work),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_work  (pop_work)
    );

    // accumulation and result
    sit_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_work   (pop_work),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_tensor (o_tensor)
    );

endmodule

/* design/sit_cfg.sv */
// APB register file for the shell radii, plus registered squared radii
// depends on sit_pkg
`timescale 1ns / 1ps

module sit_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sit_pkg::ADDR_W-1:0] paddr,
    input  logic [sit_pkg::DATA_W-1:0] pwdata,
    output logic [sit_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output sit_pkg::t_shell            o_shell
);
    import sit_pkg::*;

    logic [RADIUS_W-1:0] r_inner;
    logic [RADIUS_W-1:0] r_outer;
    t_rsq                r_inner_sq;
    t_rsq                r_outer_sq;
    logic                reg_idx;
    logic                wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner <= INNER_RESET;
            r_outer <= OUTER_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_INNER: r_inner <= pwdata[RADIUS_W-1:0];
                REG_OUTER: r_outer <= pwdata[RADIUS_W-1:0];
                default:   ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_INNER: prdata = DATA_W'(r_inner);
            REG_OUTER: prdata = DATA_W'(r_outer);
            default:   prdata = '0;
        endcase
    end

    // squared radii, registered in the cycle after the radius registers
    always_ff @(posedge i_clk) begin
        r_inner_sq <= r_inner * r_inner;
        r_outer_sq <= r_outer * r_outer;
    end

    assign o_shell.inner_sq = r_inner_sq;
    assign o_shell.outer_sq = r_outer_sq;

endmodule

/* design/sit_front.sv */
// front end: takes particles, forms squares and cross products, tests the shell and
// pushes hits and every last particle into the work queue; depends on sit_pkg
`timescale 1ns / 1ps

module sit_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sit_in_if.sink          i_particle,
    input  sit_pkg::t_shell i_shell,
    input  logic            i_full,
    output logic            o_push,
    output sit_pkg::t_work  o_work
);
    import sit_pkg::*;

    t_pos  cx, cy, cz;
    t_prod sq_x_full, sq_y_full, sq_z_full;
    logic  en;
    logic  take;
    logic  hit;

    // stage 1 registers: products
    logic  r_s1_valid;
    t_sq   r_s1_sq_x, r_s1_sq_y, r_s1_sq_z;
    t_prod r_s1_xy, r_s1_xz, r_s1_yz;
    t_mass r_s1_mass;
    logic  r_s1_last;

    // stage 2 registers: sums
    logic  r_s2_valid;
    t_r2   r_s2_r2;
    t_r2   r_s2_yz, r_s2_xz, r_s2_xy;
    t_prod r_s2_pxy, r_s2_pxz, r_s2_pyz;
    t_mass r_s2_mass;
    logic  r_s2_last;

    // the whole front moves together, held only by a full queue
    assign hit    = (r_s2_r2 > R2_W'(i_shell.inner_sq)) &&
                    (r_s2_r2 < R2_W'(i_shell.outer_sq));
    assign o_push = r_s2_valid && (hit || r_s2_last) && !i_full;
    assign en     = !(r_s2_valid && (hit || r_s2_last)) || !i_full;
    assign take   = en && i_particle.valid;
    assign i_particle.ready = en;

    assign cx = sext_coord(i_particle.pos_x);
    assign cy = sext_coord(i_particle.pos_y);
    assign cz = sext_coord(i_particle.pos_z);
    assign sq_x_full = cx * cx;
    assign sq_y_full = cy * cy;
    assign sq_z_full = cz * cz;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= take;
            r_s2_valid <= r_s1_valid;
        end
    end

    // stage 1: six multipliers on the incoming transfer
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_sq_x <= sq_x_full[SQ_W-1:0];
            r_s1_sq_y <= sq_y_full[SQ_W-1:0];
            r_s1_sq_z <= sq_z_full[SQ_W-1:0];
            r_s1_xy   <= cx * cy;
            r_s1_xz   <= cx * cz;
            r_s1_yz   <= cy * cz;
            r_s1_mass <= i_particle.particle_mass & MASS_MASK;
            r_s1_last <= i_particle.last_particle;
        end
    end

    // stage 2: squared radius and diagonal sums
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_r2   <= {1'b0, r_s1_sq_x} + {1'b0, r_s1_sq_y} + {1'b0, r_s1_sq_z};
            r_s2_yz   <= {1'b0, r_s1_sq_y} + {1'b0, r_s1_sq_z};
            r_s2_xz   <= {1'b0, r_s1_sq_x} + {1'b0, r_s1_sq_z};
            r_s2_xy   <= {1'b0, r_s1_sq_x} + {1'b0, r_s1_sq_y};
            r_s2_pxy  <= r_s1_xy;
            r_s2_pxz  <= r_s1_xz;
            r_s2_pyz  <= r_s1_yz;
            r_s2_mass <= r_s1_mass;
            r_s2_last <= r_s1_last;
        end
    end

    // queue entry
    assign o_work.mass    = r_s2_mass;
    assign o_work.sum_yz  = r_s2_yz;
    assign o_work.sum_xz  = r_s2_xz;
    assign o_work.sum_xy  = r_s2_xy;
    assign o_work.prod_xy = r_s2_pxy;
    assign o_work.prod_xz = r_s2_pxz;
    assign o_work.prod_yz = r_s2_pyz;
    assign o_work.hit     = hit;
    assign o_work.last    = r_s2_last;

endmodule

/* design/sit_queue.sv */
// small work queue between the front and back ends
// depends on sit_pkg
`timescale 1ns / 1ps

module sit_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sit_pkg::t_work i_work,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output sit_pkg::t_work o_work
);
    import sit_pkg::*;

    t_work             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_work  = r_mem[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

endmodule

/* design/sit_back.sv */
// back end: mass-weighted terms, saturating tensor accumulators, count and
// result register; depends on sit_pkg and sit_out_if
`timescale 1ns / 1ps

module sit_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sit_pkg::t_work i_work,
    input  logic           i_empty,
    output logic           o_pop,
    sit_out_if.source      o_tensor
);
    import sit_pkg::*;

    localparam int NUM_ACC = 6;

    logic en;
    logic step;

    // term stage
    logic  r_b1_valid;
    logic  r_b1_hit;
    logic  r_b1_last;
    t_term r_term [NUM_ACC];

    logic        [MASS_W+R2_W-1:0] dprod [3];
    logic signed [MASS_W+PROD_W:0] cprod [3];
    t_r2                           dsum  [3];
    t_prod                         cpair [3];
    t_term                         n_term [NUM_ACC];

    // accumulation state
    t_acc   r_acc [NUM_ACC];
    t_count r_count;
    logic   r_sat;
    t_acc   n_acc [NUM_ACC];
    t_count n_count;
    logic   n_sat;
    logic   [ACC_W:0] wide_sum [NUM_ACC];
    logic   [NUM_ACC-1:0] ovf;

    // result register
    logic   r_out_valid;
    t_acc   r_out_acc [NUM_ACC];
    t_count r_out_count;
    logic   r_out_sat;

    // back end waits only while a result sits untaken
    assign en    = !r_out_valid || o_tensor.ready;
    assign o_pop = en && !i_empty;
    assign step  = en && r_b1_valid;

    // mass times diagonal sums and cross products
    assign dsum[0]  = i_work.sum_yz;
    assign dsum[1]  = i_work.sum_xz;
    assign dsum[2]  = i_work.sum_xy;
    assign cpair[0] = i_work.prod_xy;
    assign cpair[1] = i_work.prod_xz;
    assign cpair[2] = i_work.prod_yz;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dprod[k] = i_work.mass * dsum[k];
            cprod[k] = $signed({1'b0, i_work.mass}) * cpair[k];
        end
        n_term[0] = $signed({1'b0, dprod[0][MASS_W+R2_W-1:TERM_SHIFT]});
        n_term[1] = -$signed(cprod[0][MASS_W+PROD_W:TERM_SHIFT]);
        n_term[2] = -$signed(cprod[1][MASS_W+PROD_W:TERM_SHIFT]);
        n_term[3] = $signed({1'b0, dprod[1][MASS_W+R2_W-1:TERM_SHIFT]});
        n_term[4] = -$signed(cprod[2][MASS_W+PROD_W:TERM_SHIFT]);
        n_term[5] = $signed({1'b0, dprod[2][MASS_W+R2_W-1:TERM_SHIFT]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
        end else if (en) begin
            r_b1_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b1_hit  <= i_work.hit;
            r_b1_last <= i_work.last;
            for (int k = 0; k < NUM_ACC; k++) begin
                r_term[k] <= n_term[k];
            end
        end
    end

    // saturating adds, one per tensor element
    always_comb begin
        for (int k = 0; k < NUM_ACC; k++) begin
            wide_sum[k] = {r_acc[k][ACC_W-1], r_acc[k]}
                        + {{(ACC_W+1-TERM_W){r_term[k][TERM_W-1]}}, r_term[k]};
            ovf[k] = wide_sum[k][ACC_W] ^ wide_sum[k][ACC_W-1];
            if (!r_b1_hit) begin
                n_acc[k] = r_acc[k];
            end else if (ovf[k]) begin
                n_acc[k] = wide_sum[k][ACC_W] ? ACC_MIN : ACC_MAX;
            end else begin
                n_acc[k] = wide_sum[k][ACC_W-1:0];
            end
        end
        n_count = (r_b1_hit && r_count != COUNT_MAX) ? r_count + 1'b1 : r_count;
        n_sat   = r_sat || (r_b1_hit && (ovf != '0));
    end

    // accumulators clear after the last particle of a set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_ACC; k++) begin
                r_acc[k] <= '0;
            end
            r_count <= '0;
            r_sat   <= 1'b0;
        end else if (step) begin
            for (int k = 0; k < NUM_ACC; k++) begin
                r_acc[k] <= r_b1_last ? '0 : n_acc[k];
            end
            r_count <= r_b1_last ? '0 : n_count;
            r_sat   <= r_b1_last ? 1'b0 : n_sat;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_b1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_tensor.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_b1_last) begin
            for (int k = 0; k < NUM_ACC; k++) begin
                r_out_acc[k] <= n_acc[k];
            end
            r_out_count <= n_count;
            r_out_sat   <= n_sat;
        end
    end

    assign o_tensor.valid         = r_out_valid;
    assign o_tensor.tensor_xx     = r_out_acc[0];
    assign o_tensor.tensor_xy     = r_out_acc[1];
    assign o_tensor.tensor_xz     = r_out_acc[2];
    assign o_tensor.tensor_yy     = r_out_acc[3];
    assign o_tensor.tensor_yz     = r_out_acc[4];
    assign o_tensor.tensor_zz     = r_out_acc[5];
    assign o_tensor.shell_count   = r_out_count;
    assign o_tensor.overflow_flag = r_out_sat;

endmodule
